// ===== rtl/i2cfb_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cfb_pkg: shared types and constants for the i2c command frame buffer
// Frame geometry, bus event codes and the transfer payload structs.
// ----------------------------------------------------------------------------
package i2cfb_pkg;

    // data bytes carried after the port and function bytes
    localparam int DATA_BYTES = 4;
    // ports below this value are valid
    localparam int PORT_COUNT = 8;

    localparam int FRAME_LEN  = DATA_BYTES + 2;
    localparam int IDX_W      = $clog2(FRAME_LEN);
    localparam int DATA_W     = 8 * DATA_BYTES;

    // bus event codes
    typedef enum logic [3:0] {
        CMD_ADDR_WRITE    = 4'd0,
        CMD_RX_ACK        = 4'd1,
        CMD_RX_NACK       = 4'd2,
        CMD_STOP          = 4'd3,
        CMD_ADDR_READ     = 4'd4,
        CMD_TX_ACK        = 4'd5,
        CMD_TX_DONE       = 4'd6,
        CMD_OTHER         = 4'd7,
        CMD_LOAD_RESPONSE = 4'd8
    } cmd_t;

    typedef struct packed {
        logic [3:0]        command;
        logic [7:0]        rx_byte;
        logic signed [7:0] ret_code;
        logic [7:0]        function_id;
        logic [31:0]       payload;
        logic              has_payload;
    } item_t;

    typedef struct packed {
        logic        ack_enable;
        logic [7:0]  tx_byte;
        logic        frame_ready;
        logic [7:0]  frame_port;
        logic [7:0]  frame_function;
        logic [31:0] frame_data;
        logic        bad_port;
    } result_t;

endpackage

// ===== rtl/i2cfb_core.sv =====
// ----------------------------------------------------------------------------
// i2cfb_core: frame buffer, byte index and held frame registers
// Applies one bus event per strobe and presents the matching result.
// ----------------------------------------------------------------------------
module i2cfb_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  i2cfb_pkg::item_t  item,
    output i2cfb_pkg::result_t result
);

    localparam logic [i2cfb_pkg::IDX_W-1:0] LAST_SLOT =
        i2cfb_pkg::IDX_W'(i2cfb_pkg::FRAME_LEN - 1);

    logic [7:0]                  buf_reg  [i2cfb_pkg::FRAME_LEN];
    logic [7:0]                  buf_next [i2cfb_pkg::FRAME_LEN];
    logic [i2cfb_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                        ready_reg, ready_next;
    logic [7:0]                  tx_reg, tx_next;
    logic [7:0]                  port_reg, port_next;
    logic [7:0]                  func_reg, func_next;
    logic [31:0]                 data_reg, data_next;

    logic                        ack;
    logic                        bad;
    logic [i2cfb_pkg::DATA_W-1:0] buf_data;
    logic [i2cfb_pkg::DATA_W-1:0] load_data;

    // data bytes of the buffer, little endian
    always_comb
    begin
        for (int k = 0; k < i2cfb_pkg::DATA_BYTES; k++)
        begin
            buf_data[8*k +: 8] = buf_reg[2 + k];
        end
    end

    // payload beyond four bytes loads as zero
    assign load_data = i2cfb_pkg::DATA_W'(item.payload);

    always_comb
    begin
        buf_next   = buf_reg;
        idx_next   = idx_reg;
        ready_next = ready_reg;
        tx_next    = tx_reg;
        port_next  = port_reg;
        func_next  = func_reg;
        data_next  = data_reg;
        ack        = 1'b1;
        bad        = 1'b0;
        unique case (item.command)
            i2cfb_pkg::CMD_ADDR_WRITE, i2cfb_pkg::CMD_TX_DONE:
            begin
                idx_next   = '0;
                ready_next = 1'b0;
            end
            i2cfb_pkg::CMD_RX_ACK, i2cfb_pkg::CMD_TX_ACK:
            begin
                if (idx_reg <= LAST_SLOT)
                begin
                    if (item.command == i2cfb_pkg::CMD_RX_ACK)
                        buf_next[idx_reg] = item.rx_byte;
                    else
                        tx_next = buf_reg[idx_reg];
                    if (idx_reg < LAST_SLOT)
                        idx_next = idx_reg + 1'b1;
                    else
                        ack = 1'b0;
                end
                else
                begin
                    ack = 1'b0;
                end
            end
            i2cfb_pkg::CMD_RX_NACK:
            begin
                idx_next = '0;
                ack      = 1'b0;
            end
            i2cfb_pkg::CMD_STOP:
            begin
                if (idx_reg == LAST_SLOT)
                begin
                    port_next = buf_reg[0];
                    if (buf_reg[0] < 8'(i2cfb_pkg::PORT_COUNT))
                    begin
                        ready_next = 1'b1;
                        func_next  = buf_reg[1];
                        data_next  = 32'(buf_data);
                    end
                    else
                    begin
                        ready_next = 1'b0;
                        bad        = 1'b1;
                    end
                    ack = 1'b0;
                end
                else
                begin
                    ready_next = 1'b0;
                end
            end
            i2cfb_pkg::CMD_ADDR_READ:
            begin
                tx_next  = buf_reg[0];
                idx_next = i2cfb_pkg::IDX_W'(1);
            end
            i2cfb_pkg::CMD_LOAD_RESPONSE:
            begin
                buf_next[0] = item.ret_code;
                buf_next[1] = item.function_id;
                for (int k = 0; k < i2cfb_pkg::DATA_BYTES; k++)
                begin
                    buf_next[2 + k] = item.has_payload ? load_data[8*k +: 8] : 8'd0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < i2cfb_pkg::FRAME_LEN; k++)
            begin
                buf_reg[k] <= 8'd0;
            end
            idx_reg   <= '0;
            ready_reg <= 1'b0;
            tx_reg    <= 8'd0;
            port_reg  <= 8'd0;
            func_reg  <= 8'd0;
            data_reg  <= 32'd0;
        end
        else if (step)
        begin
            buf_reg   <= buf_next;
            idx_reg   <= idx_next;
            ready_reg <= ready_next;
            tx_reg    <= tx_next;
            port_reg  <= port_next;
            func_reg  <= func_next;
            data_reg  <= data_next;
        end
    end

    assign result.ack_enable     = ack;
    assign result.tx_byte        = tx_next;
    assign result.frame_ready    = ready_next;
    assign result.frame_port     = port_next;
    assign result.frame_function = func_next;
    assign result.frame_data     = data_next;
    assign result.bad_port       = bad;

endmodule

// ===== rtl/i2c_slave_command_frame_buffer_unit.sv =====
// ----------------------------------------------------------------------------
// i2c_slave_command_frame_buffer_unit: i2c slave fixed-length frame buffer
// Takes decoded bus events and reports acknowledge, transmit byte and the
// last frame received from the master.
// ----------------------------------------------------------------------------
// usage
//   item channel: one decoded bus event per transfer (item_valid/item_ready),
//     with the received byte and, for a load response, the reply fields
//   result channel: one result per event (result_valid/result_ready) giving
//     the acknowledge to drive, the byte for the next read slot, the held
//     frame and a bad port pulse
//   result path: the result of an event is registered in the result register or the skid register
//   throughput: one event per cycle while the skid entry is empty, set by the
//     single buffer update between the state registers and the result register
//   a two-entry output stage (result register plus skid register) keeps
//     events flowing while the receiver stalls; item_ready drops only when
//     both entries hold results that are not yet taken
//   reset clears the frame buffer, byte index, held frame and both output
//     entries at once; no event is lost or repeated across a stall
// ----------------------------------------------------------------------------
module i2c_slave_command_frame_buffer_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  i2cfb_pkg::item_t    item,
    output logic                result_valid,
    input  logic                result_ready,
    output i2cfb_pkg::result_t  result
);

    // result of the event on the item port
    i2cfb_pkg::result_t step_result;

    i2cfb_pkg::result_t out_reg;
    i2cfb_pkg::result_t skid_reg;
    logic               out_valid_reg;
    logic               skid_valid_reg;

    logic               push;
    logic               pop;

    // the skid entry is the last free slot, so accept while it is empty
    assign item_ready = !skid_valid_reg;
    assign push       = item_valid && item_ready;
    assign pop        = out_valid_reg && result_ready;

    // state only advances on an accepted transfer
    i2cfb_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (push),
        .item   (item),
        .result (step_result)
    );

    // control of the two output entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            // skid refills the output; a push cannot coincide with a full skid
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                out_valid_reg <= push;
        end
        else if (push)
        begin
            if (!out_valid_reg)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
    end

    // payload of the two output entries
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (push)
                out_reg <= step_result;
        end
        else if (push)
        begin
            if (!out_valid_reg)
                out_reg <= step_result;
            else
                skid_reg <= step_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // skid only ever holds the younger of two pending results
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid without output entry");

    // an accepted transfer always leaves a result on offer
    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> out_valid_reg)
        else $error("accepted transfer left no result");

    // skid fills only when the output was held by a stall
    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !result_ready && push))
        else $error("skid entry filled without a stall");

    // a bad port frame is never published and always answered with nack
    a_bad_port: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.bad_port) |-> (!out_reg.frame_ready && !out_reg.ack_enable))
        else $error("bad port result with ready frame or ack");

endmodule
